/* rtl/gdfr_pkg.sv */
// Shared constants, codes and handshake types for the depth-first reach block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package gdfr_pkg;

    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 1024;
    localparam int VtxW        = $clog2(MaxVertices);
    localparam int CntW        = VtxW + 1;
    localparam int EdgeAw      = $clog2(MaxEdges);
    localparam int EdgeCntW    = EdgeAw + 1;
    localparam int LvlW        = 7;

    localparam logic [LvlW-1:0] NoneVal = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR      = 2'd0,
        CMD_ADD        = 2'd1,
        CMD_SEARCH_ONE = 2'd2,
        CMD_SEARCH_ALL = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_ADD,
        DP_BAD,
        DP_INIT,
        DP_PLANT,
        DP_NEXT,
        DP_POP,
        DP_LOADU,
        DP_HEAD,
        DP_EDGE,
        DP_RDRES,
        DP_LOADOUT,
        DP_NEXTI
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   take;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      bad_start;
        logic      root_end;
        logic      root_seen;
        logic      stack_empty;
        logic      u_ok;
        logic      edge_last;
        logic      out_last;
        logic      out_taken;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/gdfr_ctrl.sv */
// Sequencer for the depth-first reach block: decodes items and steps the walk.
// Depends on gdfr_pkg; drives the datapath by command and reads its status.
`default_nettype none

module gdfr_ctrl
    import gdfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PLANT,
        S_SCAN,
        S_POP,
        S_LOADU,
        S_HEAD,
        S_EDGE,
        S_RD,
        S_RES,
        S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;
    t_dp_op w_op;

    always_comb begin
        n_state = r_state;
        w_op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_CLEAR: begin
                        w_op    = DP_CLEAR;
                        n_state = S_WAIT;
                    end
                    CMD_ADD: begin
                        w_op    = DP_ADD;
                        n_state = S_WAIT;
                    end
                    CMD_SEARCH_ONE: begin
                        if (i_stat.bad_start) begin
                            w_op    = DP_BAD;
                            n_state = S_WAIT;
                        end else begin
                            w_op    = DP_INIT;
                            n_state = S_PLANT;
                        end
                    end
                    default: begin
                        w_op    = DP_INIT;
                        n_state = S_SCAN;
                    end
                endcase
            end
            S_PLANT: begin
                w_op    = DP_PLANT;
                n_state = S_POP;
            end
            S_SCAN: begin
                if (i_stat.root_end) begin
                    n_state = S_RD;
                end else if (i_stat.root_seen) begin
                    w_op = DP_NEXT;
                end else begin
                    w_op    = DP_PLANT;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_stat.stack_empty) begin
                    if (i_stat.cmd == CMD_SEARCH_ALL) begin
                        w_op    = DP_NEXT;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    w_op    = DP_POP;
                    n_state = S_LOADU;
                end
            end
            S_LOADU: begin
                w_op    = DP_LOADU;
                n_state = i_stat.u_ok ? S_HEAD : S_POP;
            end
            S_HEAD: begin
                w_op    = DP_HEAD;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                w_op = DP_EDGE;
                if (i_stat.edge_last) n_state = S_POP;
            end
            S_RD: begin
                w_op    = DP_RDRES;
                n_state = S_RES;
            end
            S_RES: begin
                w_op    = DP_LOADOUT;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.out_taken) begin
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_op    = DP_NEXTI;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall     = r_stall;
    assign o_cmd.op    = w_op;
    assign o_cmd.take  = (r_state == S_IDLE) && i_valid;

`ifndef ASSERT_OFF
    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall == (r_state != S_IDLE))
        else $error("stall out of step with state");
    a_take_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == S_DECODE)
        else $error("accepted item not decoded");
    a_wait_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && !i_stat.out_taken) |=> r_state == S_WAIT)
        else $error("result left before taken");
`endif

endmodule

`default_nettype wire

/* rtl/gdfr_dpath.sv */
// Datapath: edge store, adjacency lists, walk stack, result store and output register.
// Depends on gdfr_pkg; acts on commands from gdfr_ctrl and returns status.
`default_nettype none

module gdfr_dpath
    import gdfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CntW-1:0]   i_cfg_wr_data,
    input  wire logic [1:0]        i_cmd_code,
    input  wire logic [VtxW-1:0]   i_src_vertex,
    input  wire logic [VtxW-1:0]   i_dst_vertex,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [VtxW-1:0]        o_vertex,
    output logic signed [LvlW-1:0] o_level,
    output logic signed [LvlW-1:0] o_parent,
    output logic                   o_last,
    output logic [1:0]             o_status
);

    logic [VtxW-1:0]     r_edge_target [MaxEdges];
    logic [EdgeAw-1:0]   r_edge_link   [MaxEdges];
    logic [EdgeAw-1:0]   r_list_head   [MaxVertices];
    logic [EdgeAw-1:0]   r_list_tail   [MaxVertices];
    logic [2*LvlW-1:0]   r_res         [MaxVertices];
    logic [VtxW-1:0]     r_stack       [MaxVertices];

    logic [VtxW-1:0]     r_target_q;
    logic [EdgeAw-1:0]   r_link_q;
    logic [EdgeAw-1:0]   r_head_q;
    logic [EdgeAw-1:0]   r_tail_q;
    logic [2*LvlW-1:0]   r_res_q;
    logic [VtxW-1:0]     r_stack_q;

    logic [CntW-1:0]        r_vcount;
    logic [MaxVertices-1:0] r_visited;
    logic [MaxVertices-1:0] r_head_valid;
    logic [EdgeCntW-1:0]    r_edges_used;
    logic [CntW-1:0]        r_sp;
    logic [CntW-1:0]        r_root;
    logic [VtxW-1:0]        r_i;
    logic [VtxW-1:0]        r_u;
    logic [EdgeAw-1:0]      r_tail;
    logic [EdgeAw-1:0]      r_e;
    logic [LvlW-1:0]        r_lvl;
    t_cmd_code              r_cmd;
    logic [VtxW-1:0]        r_src;
    logic [VtxW-1:0]        r_dst;

    logic                   r_out_valid;
    logic [VtxW-1:0]        r_o_vertex;
    logic [LvlW-1:0]        r_o_level;
    logic [LvlW-1:0]        r_o_parent;
    logic                   r_o_last;
    t_status                r_o_status;

    logic [CntW-1:0]     w_count;
    logic [CntW-1:0]     w_sp_dec;
    logic [EdgeAw-1:0]   w_edge_ra;
    logic [VtxW-1:0]     w_list_ra;
    logic [VtxW-1:0]     w_res_ra;
    logic                w_rng_bad;
    logic                w_full;
    logic                w_add_ok;
    logic                w_push;
    logic                w_plant;
    logic                w_load_out;
    logic                w_out_taken;
    logic [CntW-1:0]     w_i_next;

    always_comb begin
        if (r_vcount == '0) begin
            w_count = CntW'(1);
        end else if (r_vcount > CntW'(MaxVertices)) begin
            w_count = CntW'(MaxVertices);
        end else begin
            w_count = r_vcount;
        end
    end

    assign w_sp_dec    = r_sp - CntW'(1);
    assign w_edge_ra   = (i_cmd.op == DP_HEAD) ? r_head_q : r_link_q;
    assign w_list_ra   = (i_cmd.op == DP_LOADU) ? r_stack_q : i_src_vertex;
    assign w_res_ra    = (i_cmd.op == DP_LOADU) ? r_stack_q : r_i;
    assign w_rng_bad   = ({1'b0, r_src} >= w_count) || ({1'b0, r_dst} >= w_count);
    assign w_full      = (r_edges_used == EdgeCntW'(MaxEdges));
    assign w_add_ok    = (i_cmd.op == DP_ADD) && !w_rng_bad && !w_full;
    assign w_plant     = (i_cmd.op == DP_PLANT);
    assign w_push      = (i_cmd.op == DP_EDGE) && ({1'b0, r_target_q} < w_count)
                         && !r_visited[r_target_q] && (r_sp < CntW'(MaxVertices));
    assign w_load_out  = (i_cmd.op == DP_CLEAR) || (i_cmd.op == DP_ADD)
                         || (i_cmd.op == DP_BAD) || (i_cmd.op == DP_LOADOUT);
    assign w_out_taken = r_out_valid && !i_stall;
    assign w_i_next    = {1'b0, r_i} + CntW'(1);

    // memories
    always_ff @(posedge i_clk) begin
        r_target_q <= r_edge_target[w_edge_ra];
        r_link_q   <= r_edge_link[w_edge_ra];
        r_head_q   <= r_list_head[w_list_ra];
        r_tail_q   <= r_list_tail[w_list_ra];
        r_res_q    <= r_res[w_res_ra];
        r_stack_q  <= r_stack[w_sp_dec[VtxW-1:0]];
        if (w_add_ok) begin
            r_edge_target[r_edges_used[EdgeAw-1:0]] <= r_dst;
            r_list_tail[r_src] <= r_edges_used[EdgeAw-1:0];
        end
        if (w_add_ok && r_head_valid[r_src]) begin
            r_edge_link[r_tail_q] <= r_edges_used[EdgeAw-1:0];
        end
        if (w_add_ok && !r_head_valid[r_src]) begin
            r_list_head[r_src] <= r_edges_used[EdgeAw-1:0];
        end
        if (w_plant) begin
            r_res[r_root[VtxW-1:0]]   <= {{LvlW{1'b0}}, NoneVal};
            r_stack[r_sp[VtxW-1:0]]   <= r_root[VtxW-1:0];
        end else if (w_push) begin
            r_res[r_target_q]       <= {r_lvl + LvlW'(1), 1'b0, r_u};
            r_stack[r_sp[VtxW-1:0]] <= r_target_q;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount     <= CntW'(MaxVertices);
            r_visited    <= '0;
            r_head_valid <= '0;
            r_edges_used <= '0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_vcount <= i_cfg_wr_data;
            case (i_cmd.op)
                DP_CLEAR: begin
                    r_head_valid <= '0;
                    r_edges_used <= '0;
                end
                DP_INIT: begin
                    r_visited <= '0;
                    r_sp      <= '0;
                end
                DP_PLANT: begin
                    r_visited[r_root[VtxW-1:0]] <= 1'b1;
                    r_sp <= r_sp + CntW'(1);
                end
                DP_POP: r_sp <= w_sp_dec;
                default: ;
            endcase
            if (w_add_ok) begin
                r_head_valid[r_src] <= 1'b1;
                r_edges_used <= r_edges_used + EdgeCntW'(1);
            end
            if (w_push) begin
                r_visited[r_target_q] <= 1'b1;
                r_sp <= r_sp + CntW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cmd <= t_cmd_code'(i_cmd_code);
            r_src <= i_src_vertex;
            r_dst <= i_dst_vertex;
        end
        case (i_cmd.op)
            DP_INIT: begin
                r_root <= (r_cmd == CMD_SEARCH_ONE) ? {1'b0, r_src} : '0;
                r_i    <= '0;
            end
            DP_NEXT:  r_root <= r_root + CntW'(1);
            DP_NEXTI: r_i    <= r_i + VtxW'(1);
            DP_LOADU: r_u    <= r_stack_q;
            DP_HEAD: begin
                r_tail <= r_tail_q;
                r_lvl  <= r_res_q[2*LvlW-1:LvlW];
                r_e    <= r_head_q;
            end
            DP_EDGE: begin
                if (r_e != r_tail) r_e <= r_link_q;
            end
            default: ;
        endcase
        case (i_cmd.op)
            DP_CLEAR, DP_ADD: begin
                r_o_vertex <= '0;
                r_o_level  <= NoneVal;
                r_o_parent <= NoneVal;
                r_o_last   <= 1'b1;
                if (i_cmd.op == DP_CLEAR) r_o_status <= STAT_OK;
                else if (w_rng_bad)       r_o_status <= STAT_RANGE;
                else if (w_full)          r_o_status <= STAT_FULL;
                else                      r_o_status <= STAT_OK;
            end
            DP_BAD: begin
                r_o_vertex <= r_src;
                r_o_level  <= NoneVal;
                r_o_parent <= NoneVal;
                r_o_last   <= 1'b1;
                r_o_status <= STAT_RANGE;
            end
            DP_LOADOUT: begin
                r_o_vertex <= r_i;
                r_o_level  <= r_visited[r_i] ? r_res_q[2*LvlW-1:LvlW] : NoneVal;
                r_o_parent <= r_visited[r_i] ? r_res_q[LvlW-1:0] : NoneVal;
                r_o_last   <= (w_i_next == w_count);
                r_o_status <= STAT_OK;
            end
            default: ;
        endcase
    end

    assign o_stat.cmd         = r_cmd;
    assign o_stat.bad_start   = ({1'b0, r_src} >= w_count);
    assign o_stat.root_end    = (r_root == w_count);
    assign o_stat.root_seen   = r_visited[r_root[VtxW-1:0]];
    assign o_stat.stack_empty = (r_sp == '0);
    assign o_stat.u_ok        = r_head_valid[r_stack_q];
    assign o_stat.edge_last   = (r_e == r_tail);
    assign o_stat.out_last    = r_o_last;
    assign o_stat.out_taken   = w_out_taken;

    assign o_valid  = r_out_valid;
    assign o_vertex = r_o_vertex;
    assign o_level  = r_o_level;
    assign o_parent = r_o_parent;
    assign o_last   = r_o_last;
    assign o_status = r_o_status;

`ifndef ASSERT_OFF
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CntW'(MaxVertices))
        else $error("walk stack overrun");
    a_edges_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges_used <= EdgeCntW'(MaxEdges))
        else $error("edge count overrun");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_load_out))
        else $error("item raised without load");
    a_push_visit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_visited[$past(r_target_q)])
        else $error("pushed vertex not marked");
`endif

endmodule

`default_nettype wire

/* rtl/graph_depth_first_reach.sv */
// Top level of the depth-first reach block: joins sequencer and datapath.
// Depends on gdfr_pkg, gdfr_ctrl and gdfr_dpath.
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       i_cmd, i_src_vertex, i_dst_vertex
//   output    out        o_valid / i_stall       o_vertex, o_level, o_parent, o_last, o_status
//   config    in         i_cfg_wr_en             i_cfg_wr_data (vertex count)
//
// Clear and add edge each give one result item; one item at a time.
// A search plants the root, then pops each stacked vertex, loads its list head and scans
// its edges, pushing unvisited targets; a search of all vertices tries each root in turn.
// The edge store and stack each give one read per cycle. Results follow, one per vertex.
// Synchronous active-low reset empties all lists; no clearing pass is needed.
// A stalled result holds the block; o_stall stays high until the last result is taken.
`default_nettype none

module graph_depth_first_reach
    import gdfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CntW-1:0]   i_cfg_wr_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [VtxW-1:0]   i_src_vertex,
    input  wire logic [VtxW-1:0]   i_dst_vertex,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [VtxW-1:0]        o_vertex,
    output logic signed [LvlW-1:0] o_level,
    output logic signed [LvlW-1:0] o_parent,
    output logic                   o_last,
    output logic [1:0]             o_status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    gdfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    gdfr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_code    (i_cmd),
        .i_src_vertex  (i_src_vertex),
        .i_dst_vertex  (i_dst_vertex),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_vertex      (o_vertex),
        .o_level       (o_level),
        .o_parent      (o_parent),
        .o_last        (o_last),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

/* test/graph_depth_first_reach_tb.sv */
// Self-checking testbench for graph_depth_first_reach: loads graphs, runs
// depth-first searches and checks every result against a built-in predictor.
// Depends on gdfr_pkg and the graph_depth_first_reach RTL.
`timescale 1ns / 100ps

module graph_depth_first_reach_tb;
    import gdfr_pkg::*;

    typedef struct packed {
        t_cmd_code  cmd;
        logic [5:0] src;
        logic [5:0] dst;
    } t_req;

    typedef struct packed {
        logic [5:0]        vertex;
        logic signed [6:0] level;
        logic signed [6:0] parent;
        logic              last;
        logic [1:0]        status;
    } t_res;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_wr_en = 0;
    logic [6:0] i_cfg_wr_data = '0;
    logic       i_valid = 0;
    logic       o_stall;
    logic [1:0] i_cmd = '0;
    logic [5:0] i_src_vertex = '0;
    logic [5:0] i_dst_vertex = '0;
    logic       o_valid;
    logic       i_stall = 1;
    logic [5:0] o_vertex;
    logic signed [6:0] o_level;
    logic signed [6:0] o_parent;
    logic       o_last;
    logic [1:0] o_status;

    graph_depth_first_reach dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned vcount = 64;
    int unsigned tgt[MaxEdges];
    int unsigned lnk[MaxEdges];
    int unsigned head[MaxVertices];
    int unsigned tail[MaxVertices];
    bit          has_list[MaxVertices];
    int unsigned n_edges;
    int          lvl[MaxVertices];
    int          par[MaxVertices];

    t_req  pending_items[$];
    t_res  expected_results[$];
    int    errors = 0;
    int    hold_off = 0;
    int    in_gap = 0;
    int    out_gap = 0;
    bit    stalling = 0;

    function automatic int unsigned live_count();
        if (vcount == 0) return 1;
        if (vcount > MaxVertices) return MaxVertices;
        return vcount;
    endfunction

    function automatic t_res mk(int v, int l, int p, bit lst, t_status st);
        t_res r;
        r.vertex = 6'(v); r.level = 7'(l); r.parent = 7'(p); r.last = lst; r.status = st;
        return r;
    endfunction

    task automatic walk(int unsigned root, int unsigned cnt);
        int unsigned stk[$];
        int unsigned u, e, v, steps;
        stk.push_back(root);
        while (stk.size() > 0) begin
            u = stk.pop_back();
            if (u >= cnt || !has_list[u]) continue;
            e = head[u];
            for (steps = 0; steps < MaxEdges; steps++) begin
                v = tgt[e];
                if (v < cnt && lvl[v] < 0 && stk.size() < MaxVertices) begin
                    lvl[v] = lvl[u] + 1;
                    par[v] = u;
                    stk.push_back(v);
                end
                if (e == tail[u]) break;
                e = lnk[e];
            end
        end
    endtask

    task automatic predict_reach(t_req q);
        int unsigned cnt;
        t_status st;
        cnt = live_count();
        case (q.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < MaxVertices; i++) has_list[i] = 0;
                n_edges = 0;
                expected_results.push_back(mk(0, -1, -1, 1, STAT_OK));
            end
            CMD_ADD: begin
                st = STAT_OK;
                if (q.src >= cnt || q.dst >= cnt) st = STAT_RANGE;
                else if (n_edges >= MaxEdges) st = STAT_FULL;
                else begin
                    tgt[n_edges] = q.dst;
                    if (has_list[q.src]) lnk[tail[q.src]] = n_edges;
                    else begin
                        head[q.src] = n_edges;
                        has_list[q.src] = 1;
                    end
                    tail[q.src] = n_edges;
                    n_edges++;
                end
                expected_results.push_back(mk(0, -1, -1, 1, st));
            end
            default: begin
                if (q.cmd == CMD_SEARCH_ONE && q.src >= cnt) begin
                    expected_results.push_back(mk(q.src, -1, -1, 1, STAT_RANGE));
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        lvl[i] = -1;
                        par[i] = -1;
                    end
                    if (q.cmd == CMD_SEARCH_ONE) begin
                        lvl[q.src] = 0;
                        walk(q.src, cnt);
                    end else begin
                        for (int i = 0; i < cnt; i++)
                            if (lvl[i] < 0) begin
                                lvl[i] = 0;
                                walk(i, cnt);
                            end
                    end
                    for (int i = 0; i < cnt; i++)
                        expected_results.push_back(
                            mk(i, lvl[i], par[i], i + 1 == cnt, STAT_OK));
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // receiver hold-off, counted down in cycles
    always @(negedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (in_gap > 0) begin
                    i_valid <= 0;
                    in_gap <= in_gap - 1;
                end else if (pending_items.size() > 0 && $urandom_range(0, 3) != 0) begin
                    t_req q;
                    q = pending_items.pop_front();
                    i_valid <= 1;
                    i_cmd <= q.cmd;
                    i_src_vertex <= q.src;
                    i_dst_vertex <= q.dst;
                    if ($urandom_range(0, 19) == 0) in_gap <= $urandom_range(5, 30);
                end else begin
                    i_valid <= 0;
                end
            end
            if (hold_off > 0) begin
                i_stall <= 1;
            end else if (out_gap > 0) begin
                i_stall <= 1;
                out_gap <= out_gap - 1;
            end else if (stalling) begin
                i_stall <= $urandom_range(0, 3) == 0;
                if ($urandom_range(0, 49) == 0) out_gap <= $urandom_range(5, 30);
            end else begin
                i_stall <= ($urandom_range(0, 99) < 2) ? 1 : 0;
            end
        end
    end

    // sender side: predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            predict_reach(t_req'{t_cmd_code'(i_cmd), i_src_vertex, i_dst_vertex});
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item vertex", o_vertex, -1);
            end else begin
                t_res w;
                w = expected_results.pop_front();
                if (o_vertex !== w.vertex) report_mismatch("vertex", o_vertex, w.vertex);
                if (o_level !== w.level) report_mismatch("level", o_level, w.level);
                if (o_parent !== w.parent) report_mismatch("parent", o_parent, w.parent);
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
            end
        end
    end

    function automatic t_req req(t_cmd_code c, int s, int d);
        t_req q;
        q.cmd = c; q.src = 6'(s); q.dst = 6'(d);
        return q;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_count(int unsigned n);
        @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= 7'(n);
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        vcount = n;
    endtask

    task automatic random_graph(int unsigned cnt, int n_add);
        pending_items.push_back(req(CMD_CLEAR, $urandom, $urandom));
        for (int k = 0; k < n_add; k++)
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(req(CMD_ADD, $urandom, $urandom));
            else
                pending_items.push_back(req(CMD_ADD, $urandom_range(0, cnt - 1),
                                            $urandom_range(0, cnt - 1)));
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 1))
                pending_items.push_back(req(CMD_SEARCH_ALL, $urandom, $urandom));
            else
                pending_items.push_back(req(CMD_SEARCH_ONE, $urandom_range(0, cnt),
                                            $urandom));
        end
    endtask

    initial begin
        int unsigned cnt;
        for (int i = 0; i < MaxVertices; i++) has_list[i] = 0;
        n_edges = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed
        pending_items.push_back(req(CMD_SEARCH_ALL, 0, 0));
        pending_items.push_back(req(CMD_ADD, 0, 63));
        pending_items.push_back(req(CMD_ADD, 63, 0));
        pending_items.push_back(req(CMD_ADD, 0, 1));
        pending_items.push_back(req(CMD_ADD, 1, 2));
        pending_items.push_back(req(CMD_ADD, 2, 0));
        pending_items.push_back(req(CMD_ADD, 5, 5));
        pending_items.push_back(req(CMD_SEARCH_ONE, 0, 0));
        pending_items.push_back(req(CMD_SEARCH_ONE, 63, 42));
        pending_items.push_back(req(CMD_SEARCH_ALL, 21, 21));
        pending_items.push_back(req(CMD_CLEAR, 63, 63));
        pending_items.push_back(req(CMD_SEARCH_ONE, 7, 0));
        drain();

        // lowered count: range errors, skipped edges, bad start
        set_count(4);
        pending_items.push_back(req(CMD_ADD, 3, 0));
        pending_items.push_back(req(CMD_ADD, 4, 0));
        pending_items.push_back(req(CMD_ADD, 0, 4));
        pending_items.push_back(req(CMD_ADD, 0, 3));
        pending_items.push_back(req(CMD_SEARCH_ONE, 4, 0));
        pending_items.push_back(req(CMD_SEARCH_ONE, 3, 0));
        drain();
        set_count(64);
        pending_items.push_back(req(CMD_ADD, 3, 40));
        pending_items.push_back(req(CMD_ADD, 40, 41));
        drain();
        set_count(10);
        pending_items.push_back(req(CMD_SEARCH_ALL, 0, 0));
        drain();
        set_count(0);
        pending_items.push_back(req(CMD_SEARCH_ALL, 0, 0));
        pending_items.push_back(req(CMD_SEARCH_ONE, 1, 0));
        drain();
        set_count(127);
        pending_items.push_back(req(CMD_SEARCH_ONE, 3, 0));
        drain();

        // long receiver hold-off while items keep coming
        set_count(64);
        hold_off = 300;
        pending_items.push_back(req(CMD_CLEAR, 0, 0));
        for (int k = 0; k < 10; k++)
            pending_items.push_back(req(CMD_ADD, $urandom_range(0, 63),
                                        $urandom_range(0, 63)));
        pending_items.push_back(req(CMD_SEARCH_ALL, 0, 0));
        drain();

        // random phases
        for (int ph = 0; ph < 15; ph++) begin
            case (ph % 4)
                0: cnt = 64;
                1: cnt = 1;
                default: cnt = $urandom_range(2, 20);
            endcase
            set_count(cnt);
            stalling = ph[0];
            random_graph(cnt, $urandom_range(10, 40));
            drain();
        end

        if (errors == 0) $display("graph_depth_first_reach: match");
        else $display("graph_depth_first_reach: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("graph_depth_first_reach: mismatch");
        $finish;
    end
endmodule
